// File: rtl/core/sorted_byte_insertion_buffer_assert.svh
// Assertion macros used by the sorted byte buffer checker.
`ifndef SORTED_BYTE_INSERTION_BUFFER_ASSERT_SVH
`define SORTED_BYTE_INSERTION_BUFFER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBIB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbib assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SBIB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbib assertion failed");

`endif

// File: rtl/core/sbib_pkg.sv
// Shared types and constants for the sorted byte insertion buffer.
`default_nettype none
package sbib_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic  insert;     // place din into the chain this cycle
        logic  shift_out;  // move every entry one cell toward the head
        byte_t din;        // byte being inserted
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/sbib_cell.sv
// One compare-and-shift cell of the sorted byte chain.
`default_nettype none
module sbib_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sbib_pkg::cell_ctrl_t ctrl,
    input  wire sbib_pkg::byte_t    left_value,
    input  wire logic               left_valid,
    input  wire logic               left_ge,
    input  wire sbib_pkg::byte_t    right_value,
    input  wire logic               right_valid,
    output sbib_pkg::byte_t         value_o,
    output logic                    valid_o,
    output logic                    ge_o
);
    import sbib_pkg::*;

    byte_t value_reg, value_next;
    logic  valid_reg, valid_next;

    // An empty cell counts as greater than any byte.
    assign ge_o    = !valid_reg || (value_reg >= ctrl.din);
    assign value_o = value_reg;
    assign valid_o = valid_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift_out) begin
            value_next = right_value;
            valid_next = right_valid;
        end else if (ctrl.insert && ge_o) begin
            // take the new byte at the boundary, else take the left neighbor
            value_next = left_ge ? left_value : ctrl.din;
            valid_next = valid_reg || left_valid;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sorted_byte_insertion_buffer.sv
// A byte with tlast set gives its first sorted result (m_tvalid) in the cycle after it is taken.
// Throughput: one byte per cycle while filling; the drain then sends one byte per cycle
// while m_tready is high, as many transfers as stored bytes; no input is taken until it ends.
// Both rates follow from the registered compare-and-shift step of the cell chain.
// Reset: synchronous, active low; empties the chain and clears the overflow flag.
`default_nettype none
module sorted_byte_insertion_buffer #(
    parameter int unsigned CAPACITY = 64   // number of cells, 2 to 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] byte_value
    input  wire logic       s_tlast,   // end_of_set
    // sorted result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] sorted_byte
    output logic            m_tlast,   // last_of_run
    output logic            m_tuser    // [0] overflowed
);
    import sbib_pkg::*;

    // Padded neighbor arrays: entry 0 is the head pad, entry i+1 is cell i,
    // entry CAPACITY+1 is the tail pad.
    byte_t value_ext [0:CAPACITY+1];
    logic  valid_ext [0:CAPACITY+1];
    logic  ge_ext    [0:CAPACITY-1];

    cell_ctrl_t ctrl;

    logic draining_reg, draining_next;
    logic overflow_reg, overflow_next;

    logic s_xfer, m_xfer, m_last_xfer, full;

    // The head pad reads as a valid byte and cell 0 has its left_ge tied low, so cell 0
    // takes the new byte whenever it has to move.
    assign value_ext[0]          = '0;
    assign valid_ext[0]          = 1'b1;
    assign value_ext[CAPACITY+1] = '0;
    assign valid_ext[CAPACITY+1] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            sbib_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_value  (value_ext[0]),
                .left_valid  (valid_ext[0]),
                .left_ge     (1'b0),
                .right_value (value_ext[2]),
                .right_valid (valid_ext[2]),
                .value_o     (value_ext[1]),
                .valid_o     (valid_ext[1]),
                .ge_o        (ge_ext[0])
            );
        end else begin : g_body
            sbib_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_value  (value_ext[i]),
                .left_valid  (valid_ext[i]),
                .left_ge     (ge_ext[i-1]),
                .right_value (value_ext[i+2]),
                .right_valid (valid_ext[i+2]),
                .value_o     (value_ext[i+1]),
                .valid_o     (valid_ext[i+1]),
                .ge_o        (ge_ext[i])
            );
        end
    end

    // The chain is full once its tail cell holds a byte.
    assign full = valid_ext[CAPACITY];

    // Hold off input for the whole drain.
    assign s_tready    = !draining_reg;
    assign s_xfer      = s_tvalid && s_tready;

    // Cell 0 is the output stage; the drain presents it directly.
    assign m_tvalid    = draining_reg && valid_ext[1];
    assign m_tdata     = value_ext[1];
    assign m_tlast     = !valid_ext[2];
    assign m_tuser     = overflow_reg;
    assign m_xfer      = m_tvalid && m_tready;
    assign m_last_xfer = m_xfer && m_tlast;

    // Drop the byte when full; advance the chain on every output transfer.
    always_comb begin
        ctrl.insert    = s_xfer && !full;
        ctrl.shift_out = m_xfer;
        ctrl.din       = s_tdata;
    end

    always_comb begin
        draining_next = draining_reg;
        if (s_xfer && s_tlast) begin
            draining_next = 1'b1;
        end else if (m_last_xfer) begin
            draining_next = 1'b0;
        end
    end

    always_comb begin
        overflow_next = overflow_reg;
        if (s_xfer && full) begin
            overflow_next = 1'b1;
        end else if (m_last_xfer) begin
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draining_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end else begin
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sbib_checker.sv
// Port-level checker for the sorted byte insertion buffer, bound to the top level.
`default_nettype none
`include "sorted_byte_insertion_buffer_assert.svh"
module sbib_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);
    logic s_xfer, m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // A stalled result holds its payload.
    `SBIB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // Input is never taken while a drain is running.
    `SBIB_ASSERT_NOW(a_no_fill_in_drain, aclk, aresetn, m_tvalid, !s_tready)

    // An end-marked byte starts the drain in the next cycle.
    `SBIB_ASSERT_NEXT(a_drain_starts, aclk, aresetn, s_xfer && s_tlast, m_tvalid)

    // The flagged last transfer ends the drain.
    `SBIB_ASSERT_NEXT(a_drain_ends, aclk, aresetn, m_xfer && m_tlast, !m_tvalid && s_tready)

endmodule

bind sorted_byte_insertion_buffer sbib_checker u_sbib_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
